// ===== rtl/core/ges_pkg.sv =====
package ges_pkg;

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 4;
    localparam int OIDX_W  = 3;
    localparam int TDATA_W = 40;

    // defaults for the top-level parameters
    localparam int MAX_UNKNOWNS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int RESET_COUNT      = 8;

    // controller to datapath commands
    typedef struct packed {
        logic we;         // write matrix store
        logic wsel_in;    // write data is the input item
        logic ld_piv;     // pivot <= read data
        logic ld_a;       // operand a <= read data
        logic ld_x;       // accumulator <= read data
        logic mul_sol;    // multiplier takes a solution instead of the ratio
        logic do_mul;     // product <= operand * read data
        logic ld_mul;     // scaled product <= saturate(product)
        logic x_sub;      // accumulator <= accumulator - scaled product
        logic div_start;  // start the divider
        logic div_x;      // dividend is the accumulator instead of operand a
        logic ld_ratio;   // ratio <= quotient
        logic ld_sol;     // solution <= quotient
        logic out_err;    // result item is the error item
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic piv_zero;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/core/gauss_elimination_solver.sv =====
// channel  | dir | signals                        | contents
// ---------+-----+--------------------------------+------------------------------------
// input    | in  | i_s_tvalid/o_s_tready/i_s_tdata| coefficient, row-major
// result   | out | o_m_tvalid/i_m_tready/o_m_tdata| solution, unknown_index
//          |     | o_m_tuser, o_m_tlast           | zero_pivot_error, last
// config   | in  | i_cfg_valid/o_cfg_ready        | unknown_count
//
// loading takes one item per cycle for n*(n+1) items; the solve then runs
// on one read port of the matrix store and one bit-serial divider
// results go out one per cycle while accepted; no item is taken meanwhile
// reset is synchronous, active low, and sets unknown_count to 8
module gauss_elimination_solver #(
    parameter int MAX_UNKNOWNS = ges_pkg::MAX_UNKNOWNS_DEF,
    parameter int FRAC_BITS    = ges_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ges_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ges_pkg::DATA_W-1:0]    i_s_tdata,  // [31:0] coefficient
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ges_pkg::TDATA_W-1:0]   o_m_tdata,  // [31:0] solution, [34:32] unknown_index
    output logic                          o_m_tuser,  // [0] zero_pivot_error
    output logic                          o_m_tlast
);
    import ges_pkg::*;

    localparam int ADDR_W = $clog2(MAX_UNKNOWNS * (MAX_UNKNOWNS + 1));
    localparam int SIDX_W = $clog2(MAX_UNKNOWNS);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    logic [SIDX_W-1:0] w_sidx;
    logic [OIDX_W-1:0] w_oidx;
    logic [DATA_W-1:0] w_sol;
    logic              w_err;

    ges_ctrl #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_last      (o_m_tlast),
        .o_err       (w_err),
        .o_oidx      (w_oidx),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .o_raddr     (w_raddr),
        .o_waddr     (w_waddr),
        .o_sidx      (w_sidx)
    );

    ges_datapath #(
        .MAX_UNKNOWNS (MAX_UNKNOWNS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_raddr    (w_raddr),
        .i_waddr    (w_waddr),
        .i_sidx     (w_sidx),
        .i_coef     (i_s_tdata),
        .o_solution (w_sol)
    );

    // output packing
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {{(TDATA_W-DATA_W-OIDX_W){1'b0}}, w_oidx, w_sol};
    assign o_m_tuser   = w_err;
endmodule

// ===== rtl/core/ges_ram.sv =====
module ges_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/ges_div.sv =====
module ges_div #(
    parameter int FRAC_BITS = ges_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ges_pkg::DATA_W-1:0]  i_num,
    input  logic [ges_pkg::DATA_W-1:0]  i_den,
    output logic                        o_done,
    output logic [ges_pkg::DATA_W-1:0]  o_quot
);
    import ges_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [NW-1:0]   r_dvd;
    logic [DATA_W-1:0] r_den;
    logic            r_neg;
    logic            r_zero;
    logic [DATA_W:0] w_sh;
    logic            w_ge;
    logic            w_ovf_pos;
    logic            w_ovf_neg;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // restoring step: one quotient bit per cycle
    assign w_sh = {r_rem, r_dvd[NW-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_dvd  <= {mag(i_num), {FRAC_BITS{1'b0}}};
                r_den  <= mag(i_den);
                r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_rem <= w_ge ? DATA_W'(w_sh - {1'b0, r_den}) : DATA_W'(w_sh);
                r_dvd <= {r_dvd[NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the quotient; a zero divisor gives zero
    assign w_ovf_pos = |r_dvd[NW-1:DATA_W-1];
    assign w_ovf_neg = (|r_dvd[NW-1:DATA_W]) ||
                       (r_dvd[DATA_W-1] && (|r_dvd[DATA_W-2:0]));

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = w_ovf_neg ? {1'b1, {(DATA_W-1){1'b0}}} : (~r_dvd[DATA_W-1:0] + 1'b1);
        end else begin
            o_quot = w_ovf_pos ? {1'b0, {(DATA_W-1){1'b1}}} : r_dvd[DATA_W-1:0];
        end
    end

    assign o_done = r_done;
endmodule

// ===== rtl/core/ges_datapath.sv =====
module ges_datapath #(
    parameter int MAX_UNKNOWNS = ges_pkg::MAX_UNKNOWNS_DEF,
    parameter int FRAC_BITS    = ges_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  ges_pkg::t_cmd                                 i_cmd,
    output ges_pkg::t_sts                                 o_sts,
    input  logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] i_raddr,
    input  logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] i_waddr,
    input  logic [$clog2(MAX_UNKNOWNS)-1:0]               i_sidx,
    input  logic [ges_pkg::DATA_W-1:0]                    i_coef,
    output logic [ges_pkg::DATA_W-1:0]                    o_solution
);
    import ges_pkg::*;

    localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
    localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;

    logic [DATA_W-1:0]        w_rdata;
    logic [DATA_W-1:0]        w_wdata;
    logic [DATA_W-1:0]        w_quot;
    logic                     w_done;
    logic [DATA_W-1:0]        r_piv;
    logic [DATA_W-1:0]        r_a;
    logic [DATA_W-1:0]        r_x;
    logic [DATA_W-1:0]        r_ratio;
    logic [DATA_W-1:0]        r_mul;
    logic signed [63:0]       r_prod;
    logic [DATA_W-1:0]        r_sol [MAX_UNKNOWNS];
    logic signed [63:0]       w_round;
    logic signed [63:0]       w_scaled;
    logic [DATA_W-1:0]        w_mulsat;
    logic [DATA_W-1:0]        w_opa;

    function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) begin
            sub_sat = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sub_sat = d[DATA_W-1:0];
        end
    endfunction

    // matrix store
    ges_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    assign w_wdata = i_cmd.wsel_in ? i_coef : sub_sat(r_a, r_mul);

    // shared divider
    ges_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_x ? r_x : r_a),
        .i_den   (r_piv),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    // product scaling: truncate toward zero, then saturate
    assign w_opa    = i_cmd.mul_sol ? r_sol[i_sidx] : r_ratio;
    assign w_round  = r_prod + (r_prod[63] ? RND : 64'sd0);
    assign w_scaled = w_round >>> FRAC_BITS;

    always_comb begin
        if (w_scaled > SMAX) begin
            w_mulsat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_scaled < SMIN) begin
            w_mulsat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_mulsat = w_scaled[DATA_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_piv) begin
            r_piv <= w_rdata;
        end
        if (i_cmd.ld_a) begin
            r_a <= w_rdata;
        end
        if (i_cmd.ld_x) begin
            r_x <= w_rdata;
        end else if (i_cmd.x_sub) begin
            r_x <= sub_sat(r_x, r_mul);
        end
        if (i_cmd.do_mul) begin
            r_prod <= $signed(w_opa) * $signed(w_rdata);
        end
        if (i_cmd.ld_mul) begin
            r_mul <= w_mulsat;
        end
        if (i_cmd.ld_ratio) begin
            r_ratio <= w_quot;
        end
        if (i_cmd.ld_sol) begin
            r_sol[i_sidx] <= w_quot;
        end
    end

    assign o_sts.piv_zero = (r_piv == '0);
    assign o_sts.div_done = w_done;
    assign o_solution     = i_cmd.out_err ? '0 : r_sol[i_sidx];
endmodule

// ===== rtl/core/ges_ctrl.sv =====
module ges_ctrl #(
    parameter int MAX_UNKNOWNS = ges_pkg::MAX_UNKNOWNS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_valid,
    input  logic [ges_pkg::CFG_W-1:0]                     i_cfg_data,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    input  logic                                          i_m_tready,
    output logic                                          o_m_tvalid,
    output logic                                          o_last,
    output logic                                          o_err,
    output logic [ges_pkg::OIDX_W-1:0]                    o_oidx,
    output ges_pkg::t_cmd                                 o_cmd,
    input  ges_pkg::t_sts                                 i_sts,
    output logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] o_raddr,
    output logic [$clog2(MAX_UNKNOWNS*(MAX_UNKNOWNS+1))-1:0] o_waddr,
    output logic [$clog2(MAX_UNKNOWNS)-1:0]               o_sidx
);
    import ges_pkg::*;

    localparam int COLS   = MAX_UNKNOWNS + 1;
    localparam int ADDR_W = $clog2(MAX_UNKNOWNS * COLS);
    localparam int IDX_W  = $clog2(MAX_UNKNOWNS + 1);
    localparam int SIDX_W = $clog2(MAX_UNKNOWNS);
    localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

    typedef enum logic [4:0] {
        S_LOAD, S_E_PRD, S_E_PLD, S_E_PCHK, S_E_JRD, S_E_JLD, S_E_DIV, S_E_DIVW,
        S_E_RA, S_E_RB, S_E_Q, S_E_W, S_B_XRD, S_B_XLD, S_B_RD, S_B_MUL,
        S_B_SAT, S_B_SUB, S_B_PRD, S_B_PLD, S_B_DIV, S_B_DIVW, S_EMIT, S_ERR
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] r_lr;
    logic [IDX_W-1:0] r_lc;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_o;

    function automatic logic [IDX_W-1:0] eff_n(input int v);
        if (v < 1) begin
            eff_n = ONE;
        end else if (v > MAX_UNKNOWNS) begin
            eff_n = IDX_W'(MAX_UNKNOWNS);
        end else begin
            eff_n = IDX_W'(v);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
        addr = ADDR_W'(int'(r) * COLS + int'(c));
    endfunction

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= eff_n(RESET_COUNT);
            r_lr    <= '0;
            r_lc    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_o     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_s_tvalid) begin
                        if (r_lc == r_n) begin
                            r_lc <= '0;
                            r_lr <= r_lr + ONE;
                        end else begin
                            r_lc <= r_lc + ONE;
                        end
                        if ((r_lr == r_n - ONE) && (r_lc == r_n)) begin
                            r_lr    <= '0;
                            r_i     <= '0;
                            r_state <= S_E_PRD;
                        end
                    end
                end
                S_E_PRD: r_state <= S_E_PLD;
                S_E_PLD: r_state <= S_E_PCHK;
                S_E_PCHK: begin
                    if (i_sts.piv_zero) begin
                        r_state <= S_ERR;
                    end else if (r_i + ONE < r_n) begin
                        r_j     <= r_i + ONE;
                        r_state <= S_E_JRD;
                    end else begin
                        r_state <= S_B_XRD;
                    end
                end
                S_E_JRD: r_state <= S_E_JLD;
                S_E_JLD: r_state <= S_E_DIV;
                S_E_DIV: r_state <= S_E_DIVW;
                S_E_DIVW: begin
                    if (i_sts.div_done) begin
                        r_k     <= r_i + ONE;
                        r_state <= S_E_RA;
                    end
                end
                S_E_RA: r_state <= S_E_RB;
                S_E_RB: r_state <= S_E_Q;
                S_E_Q:  r_state <= S_E_W;
                S_E_W: begin
                    if (r_k != r_n) begin
                        r_k     <= r_k + ONE;
                        r_state <= S_E_RA;
                    end else if (r_j + ONE < r_n) begin
                        r_j     <= r_j + ONE;
                        r_state <= S_E_JRD;
                    end else begin
                        r_i     <= r_i + ONE;
                        r_state <= S_E_PRD;
                    end
                end
                S_B_XRD: r_state <= S_B_XLD;
                S_B_XLD: begin
                    if (r_i + ONE < r_n) begin
                        r_j     <= r_i + ONE;
                        r_state <= S_B_RD;
                    end else begin
                        r_state <= S_B_PRD;
                    end
                end
                S_B_RD:  r_state <= S_B_MUL;
                S_B_MUL: r_state <= S_B_SAT;
                S_B_SAT: r_state <= S_B_SUB;
                S_B_SUB: begin
                    if (r_j + ONE < r_n) begin
                        r_j     <= r_j + ONE;
                        r_state <= S_B_RD;
                    end else begin
                        r_state <= S_B_PRD;
                    end
                end
                S_B_PRD: r_state <= S_B_PLD;
                S_B_PLD: r_state <= S_B_DIV;
                S_B_DIV: r_state <= S_B_DIVW;
                S_B_DIVW: begin
                    if (i_sts.div_done) begin
                        if (r_i == '0) begin
                            r_o     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_i     <= r_i - ONE;
                            r_state <= S_B_XRD;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_m_tready) begin
                        if (r_o == r_n - ONE) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_o <= r_o + ONE;
                        end
                    end
                end
                S_ERR: begin
                    if (i_m_tready) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            // register write drops a partly loaded matrix
            if (i_cfg_valid) begin
                r_n  <= eff_n(int'(i_cfg_data));
                r_lr <= '0;
                r_lc <= '0;
            end
        end
    end

    // commands and addresses per state
    always_comb begin
        o_cmd   = '0;
        o_raddr = addr(r_i, r_i);
        o_waddr = addr(r_j, r_k);
        o_sidx  = r_o[SIDX_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                o_cmd.we      = i_s_tvalid;
                o_cmd.wsel_in = 1'b1;
                o_waddr       = addr(r_lr, r_lc);
            end
            S_E_PRD:  o_raddr = addr(r_i, r_i);
            S_E_PLD:  o_cmd.ld_piv = 1'b1;
            S_E_PCHK: o_cmd = '0;
            S_E_JRD:  o_raddr = addr(r_j, r_i);
            S_E_JLD:  o_cmd.ld_a = 1'b1;
            S_E_DIV:  o_cmd.div_start = 1'b1;
            S_E_DIVW: o_cmd.ld_ratio = i_sts.div_done;
            S_E_RA:   o_raddr = addr(r_i, r_k);
            S_E_RB: begin
                o_cmd.do_mul = 1'b1;
                o_raddr      = addr(r_j, r_k);
            end
            S_E_Q: begin
                o_cmd.ld_a   = 1'b1;
                o_cmd.ld_mul = 1'b1;
            end
            S_E_W:   o_cmd.we = 1'b1;
            S_B_XRD: o_raddr = addr(r_i, r_n);
            S_B_XLD: o_cmd.ld_x = 1'b1;
            S_B_RD:  o_raddr = addr(r_i, r_j);
            S_B_MUL: begin
                o_cmd.do_mul  = 1'b1;
                o_cmd.mul_sol = 1'b1;
                o_sidx        = r_j[SIDX_W-1:0];
            end
            S_B_SAT: o_cmd.ld_mul = 1'b1;
            S_B_SUB: o_cmd.x_sub = 1'b1;
            S_B_PRD: o_raddr = addr(r_i, r_i);
            S_B_PLD: o_cmd.ld_piv = 1'b1;
            S_B_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_x     = 1'b1;
            end
            S_B_DIVW: begin
                o_cmd.ld_sol = i_sts.div_done;
                o_sidx       = r_i[SIDX_W-1:0];
            end
            S_EMIT: o_sidx = r_o[SIDX_W-1:0];
            S_ERR:  o_cmd.out_err = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // result handshake
    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = (r_state == S_EMIT) || (r_state == S_ERR);
    assign o_err      = (r_state == S_ERR);
    assign o_last     = o_err || (r_o == r_n - ONE);
    assign o_oidx     = o_err ? '0 : OIDX_W'(r_o);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_tvalid && o_s_tready))
        else $error("input taken while results pending");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_err) |-> o_last)
        else $error("error item not marked last");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_o < r_n))
        else $error("result index beyond unknown count");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider finished too early");
endmodule

// ===== tb/tb_gauss_elimination_solver.sv =====
module tb_gauss_elimination_solver;
    import ges_pkg::*;

    localparam int MAXN = 8;
    localparam int FRAC = 16;
    localparam int COLS = MAXN + 1;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        logic [31:0] solution;
        logic [2:0]  unknown_index;
        logic        zero_pivot_error;
        logic        last;
    } t_solution_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata = '0;   // [31:0] coefficient
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;        // [31:0] solution, [34:32] unknown_index
    logic                 o_m_tuser;        // [0] zero_pivot_error
    logic                 o_m_tlast;

    // predictor state
    logic [3:0]           model_count;
    logic signed [31:0]   model_matrix [MAXN*COLS];
    logic signed [31:0]   model_sol [MAXN];
    int unsigned          model_entries;

    t_solution_item       pending_solutions [$];
    int                   error_count = 0;
    longint               cycle_count = 0;
    bit                   stall_free = 1'b0;

    gauss_elimination_solver i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_gauss_elimination_solver: errors");
            $finish;
        end
    end

    // fixed point helpers
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [65:0] p;
        logic [65:0]        m;
        p = 66'(a) * 66'(b);
        m = (p < 0) ? -p : p;
        m = m >> FRAC;
        return sat32((p < 0) ? -$signed(m) : $signed(m));
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [65:0]        num;
        logic [65:0]        den;
        logic signed [65:0] q;
        if (b == 0) return 0;
        num = (a < 0) ? -66'(a) : 66'(a);
        num = num << FRAC;
        den = (b < 0) ? -66'(b) : 66'(b);
        q = $signed(num / den);
        return sat32(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic int unsigned active_unknowns();
        if (model_count < 1) return 1;
        if (model_count > MAXN) return MAXN;
        return model_count;
    endfunction

    // elimination and back substitution; pushes the predicted results
    function automatic void predict_solve(input int unsigned n);
        logic signed [31:0] piv, ratio, x;
        t_solution_item     item;
        for (int i = 0; i < n; i++) begin
            piv = model_matrix[i*COLS+i];
            if (piv == 0) begin
                item = '{32'd0, 3'd0, 1'b1, 1'b1};
                pending_solutions.push_back(item);
                return;
            end
            for (int j = i + 1; j < n; j++) begin
                ratio = fx_div(model_matrix[j*COLS+i], piv);
                for (int k = 0; k <= n; k++)
                    model_matrix[j*COLS+k] = fx_sub(model_matrix[j*COLS+k],
                                                    fx_mul(ratio, model_matrix[i*COLS+k]));
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            x = model_matrix[i*COLS+n];
            for (int j = i + 1; j < n; j++)
                x = fx_sub(x, fx_mul(model_matrix[i*COLS+j], model_sol[j]));
            model_sol[i] = fx_div(x, model_matrix[i*COLS+i]);
        end
        for (int i = 0; i < n; i++) begin
            item = '{model_sol[i], 3'(i), 1'b0, (i + 1 == n)};
            pending_solutions.push_back(item);
        end
    endfunction

    function automatic void predict_coefficient(input logic signed [31:0] v);
        int unsigned n, total;
        n = active_unknowns();
        total = n * (n + 1);
        if (model_entries >= total) model_entries = 0;
        model_matrix[(model_entries / (n + 1)) * COLS + model_entries % (n + 1)] = v;
        model_entries++;
        if (model_entries == total) begin
            model_entries = 0;
            predict_solve(n);
        end
    endfunction

    // sends one coefficient item; valid stays up when the next item follows at once
    task automatic send_coefficient(input logic [31:0] v);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_coefficient(v);
        @(negedge i_clk);
    endtask

    // waits for all results, then lets the block settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_unknown_count(input logic [3:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_count   = value;
        model_entries = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_coefficient();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 20)) - 10) << FRAC;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    // diagonally heavy matrix so that most solves succeed
    task automatic send_system(input int unsigned n, input bit force_zero_pivot);
        logic [31:0] v;
        int          zero_row;
        zero_row = $urandom_range(0, n - 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++) begin
                v = random_coefficient();
                if (r == c)
                    v = force_zero_pivot && r == zero_row ? 32'd0
                        : ($urandom_range(0, 1) ? 32'h00400000 : 32'hffc00000) ^ (v & 32'hffff);
                else if (c < n && $urandom_range(0, 3) != 0)
                    v = $signed(v) >>> 8;
                send_coefficient(v);
            end
    endtask

    // result checking and receiver stalls
    initial begin
        t_solution_item want;
        int             wait_cycles;
        forever begin
            @(negedge i_clk);
            wait_cycles = stall_free ? 0 : $urandom_range(0, 9);
            if (wait_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            if (pending_solutions.size() == 0) begin
                $display("%0t: unexpected item sol=%h idx=%0d err=%b last=%b", $time,
                         o_m_tdata[31:0], o_m_tdata[34:32], o_m_tuser, o_m_tlast);
                error_count++;
            end else begin
                want = pending_solutions.pop_front();
                if (o_m_tdata[31:0] !== want.solution) begin
                    $display("%0t: solution expected %h actual %h", $time,
                             want.solution, o_m_tdata[31:0]);
                    error_count++;
                end
                if (o_m_tdata[34:32] !== want.unknown_index) begin
                    $display("%0t: unknown_index expected %0d actual %0d", $time,
                             want.unknown_index, o_m_tdata[34:32]);
                    error_count++;
                end
                if (o_m_tuser !== want.zero_pivot_error) begin
                    $display("%0t: zero_pivot_error expected %b actual %b", $time,
                             want.zero_pivot_error, o_m_tuser);
                    error_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_m_tlast);
                    error_count++;
                end
            end
        end
    end

    // extremes and directed cases
    task automatic test_directed();
        write_unknown_count(4'd1);
        send_coefficient(32'h00010000); send_coefficient(32'h7fffffff);
        send_coefficient(32'h80000000); send_coefficient(32'h80000000);
        send_coefficient(32'h00000000); send_coefficient(32'h00010000);
        send_coefficient(32'hffffffff); send_coefficient(32'h00000001);
        write_unknown_count(4'd0);
        send_coefficient(32'h00020000); send_coefficient(32'hfffe0000);
        write_unknown_count(4'd2);
        send_coefficient(32'h00010000); send_coefficient(32'h00020000);
        send_coefficient(32'h00030000); send_coefficient(32'h00020000);
        send_coefficient(32'h00040000); send_coefficient(32'h00050000);
        // last pivot goes to zero after elimination
        send_coefficient(32'h00010000); send_coefficient(32'h00020000);
        send_coefficient(32'h00010000); send_coefficient(32'h00020000);
        send_coefficient(32'h00040000); send_coefficient(32'h00030000);
    endtask

    // count above the store size, and a write that drops a partial load
    task automatic test_count_handling();
        write_unknown_count(4'd15);
        send_coefficient(32'h00010000); send_coefficient(32'h00020000);
        write_unknown_count(4'd8);
        send_system(8, 0);
        write_unknown_count(4'd9);
        send_system(8, 0);
    endtask

    task automatic test_random_systems();
        int unsigned n;
        for (int s = 0; s < 12; s++) begin
            stall_free = (s % 7 == 3);
            if (s % 4 == 0) begin
                n = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
                write_unknown_count(4'(n));
            end
            n = active_unknowns();
            if ($urandom_range(0, 7) == 0)
                for (int k = 0; k < n * (n + 1); k++) send_coefficient($urandom());
            else
                send_system(n, $urandom_range(0, 5) == 0);
        end
        stall_free = 1'b0;
    endtask

    initial begin
        model_count   = 4'd8;
        model_entries = 0;
        for (int k = 0; k < MAXN * COLS; k++) model_matrix[k] = 0;
        for (int k = 0; k < MAXN; k++) model_sol[k] = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_count_handling();
        test_random_systems();
        drain();
        if (error_count == 0)
            $display("tb_gauss_elimination_solver: clean");
        else
            $display("tb_gauss_elimination_solver: errors");
        $finish;
    end

endmodule

// ===== gauss_elimination_solver.f =====
rtl/core/ges_pkg.sv
rtl/core/ges_ram.sv
rtl/core/ges_div.sv
rtl/core/ges_datapath.sv
rtl/core/ges_ctrl.sv
rtl/core/gauss_elimination_solver.sv
tb/tb_gauss_elimination_solver.sv
